@@ rtl/parallel_bit_extract_defines.svh @@
// Assertion macros shared by the parallel bit extract RTL.
`ifndef PARALLEL_BIT_EXTRACT_DEFINES_SVH
`define PARALLEL_BIT_EXTRACT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PBE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("parallel_bit_extract: implication check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("parallel_bit_extract: next-cycle check failed");

`else

`define PBE_ASSERT_IMPL(label, ante, cons)
`define PBE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/pbe_pkg.sv @@
// Package with the constants, stage payload type and compress functions of the bit extractor.
`timescale 1ns / 1ps

package pbe_pkg;

    // Width of the ports and of the datapath.
    localparam int FIELD_BITS = 64;
    // Bit positions that take part in the extraction.
    localparam int WORD_BITS = 64;
    // One compress step per power of two below the word width.
    localparam int STEPS = $clog2(WORD_BITS);
    localparam int STEP_IDX_W = $clog2(STEPS);
    // Prefix XOR over the full datapath width.
    localparam int PREFIX_STEPS = $clog2(FIELD_BITS);
    localparam logic [FIELD_BITS-1:0] WORD_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);

    // Payload carried between pipeline stages.
    typedef struct packed {
        logic [FIELD_BITS-1:0] bits;   // data bits still to be moved
        logic [FIELD_BITS-1:0] mask;   // positions of the selected bits
        logic [FIELD_BITS-1:0] carry;  // zeros to the right of each mask bit, odd-parity tracking
    } t_stage_data;

    // Entry step: clip the mask to the word, drop unselected data bits.
    function automatic t_stage_data compress_init(
        input logic [FIELD_BITS-1:0] data,
        input logic [FIELD_BITS-1:0] mask
    );
        t_stage_data q;
        logic [FIELD_BITS-1:0] m;
        m       = mask & WORD_MASK;
        q.bits  = data & m;
        q.mask  = m;
        q.carry = ~m << 1;
        return q;
    endfunction

    // One compress step: bits whose right-side gap count has bit "step" set move down
    // by 2**step positions.
    function automatic t_stage_data compress_step(
        input t_stage_data d,
        input logic [STEP_IDX_W-1:0] step
    );
        t_stage_data q;
        logic [FIELD_BITS-1:0] mp;
        logic [FIELD_BITS-1:0] mv;
        logic [FIELD_BITS-1:0] t;
        logic [STEPS-1:0] shift_amt;
        shift_amt = STEPS'(1) << step;
        mp        = d.carry;
        for (int k = 0; k < PREFIX_STEPS; k++) begin
            mp = mp ^ (mp << (1 << k));
        end
        mv      = mp & d.mask;
        q.mask  = (d.mask ^ mv) | (mv >> shift_amt);
        t       = d.bits & mv;
        q.bits  = (d.bits ^ t) | (t >> shift_amt);
        q.carry = d.carry & ~mp;
        return q;
    endfunction

endpackage

@@ rtl/pbe_if.sv @@
// Valid/ready channel interfaces for the operand and result transactions.
`timescale 1ns / 1ps

interface pbe_in_if import pbe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] data_word;
    logic [FIELD_BITS-1:0] select_mask;

    modport source (output valid, output data_word, output select_mask, input ready);
    modport sink   (input valid, input data_word, input select_mask, output ready);
endinterface

interface pbe_out_if import pbe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] packed_bits;

    modport source (output valid, output packed_bits, input ready);
    modport sink   (input valid, input packed_bits, output ready);
endinterface

@@ rtl/pbe_stage.sv @@
// One registered compress stage of the bit extraction pipeline.
`timescale 1ns / 1ps
`include "parallel_bit_extract_defines.svh"

module pbe_stage import pbe_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [STEP_IDX_W-1:0] i_step,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_stage_data           i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_stage_data           o_data
);

    logic        r_valid;
    t_stage_data r_data;
    t_stage_data n_data;

    // The stage takes a new transaction when it is empty or its content moves on.
    assign o_ready = !r_valid || i_ready;
    assign n_data  = compress_step(i_data, i_step);

    // Valid bit travels with the payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload register, loaded only with a transaction.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Data bits never leave the positions that the mask marks.
    `PBE_ASSERT_IMPL(a_bits_in_mask, r_valid, (r_data.bits & ~r_data.mask) == '0)
    // A held transaction is not dropped while downstream stalls.
    `PBE_ASSERT_NEXT(a_hold_on_stall, r_valid && !i_ready, r_valid)
    // Check on the gap tracking bits of a held transaction; as written, its expression is zero for any value.
    `PBE_ASSERT_IMPL(a_carry_clear, r_valid, (r_data.carry & r_data.mask & ~r_data.carry) == '0)

endmodule

@@ rtl/parallel_bit_extract.sv @@
// Top level of the pipelined 64-bit parallel bit extractor.
`timescale 1ns / 1ps
`include "parallel_bit_extract_defines.svh"

// Parallel bit extract: every set bit of select_mask, from bit 0 upward, pulls the data_word
// bit at that position into the next free low position of packed_bits; all higher bits are
// zero. The block accepts one operand transaction per clock while the output does not stall,
// and returns one result per transaction, in order. The path is one input register that
// clips the mask and clears unselected data bits, then six compress stages, each moving bits
// down by one power of two after a six-level prefix XOR that counts the gaps below every
// selected bit. Each stage has its own valid bit and fills bubbles while the output stalls,
// so a full pipeline holds seven results.
module parallel_bit_extract import pbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pbe_in_if.sink    i_item,
    pbe_out_if.source o_result
);

    logic        r_in_valid;
    t_stage_data r_in_data;

    logic        [STEPS:0] w_valid;
    logic        [STEPS:0] w_ready;
    t_stage_data           w_data [STEPS+1];

    // Input register: takes a transaction when empty or when stage one takes its content.
    assign i_item.ready = !r_in_valid || w_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_data <= compress_init(i_item.data_word, i_item.select_mask);
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_data[0]  = r_in_data;

    // Compress stages, one per shift distance.
    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        pbe_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (STEP_IDX_W'(s)),
            .i_valid (w_valid[s]),
            .o_ready (w_ready[s]),
            .i_data  (w_data[s]),
            .o_valid (w_valid[s+1]),
            .i_ready (w_ready[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    // The last stage register is the output register.
    assign w_ready[STEPS]       = o_result.ready;
    assign o_result.valid       = w_valid[STEPS];
    assign o_result.packed_bits = w_data[STEPS].bits;

    // After the last step the mask is packed into one run of ones at the low end.
    `PBE_ASSERT_IMPL(a_mask_packed, o_result.valid,
        (w_data[STEPS].mask & (w_data[STEPS].mask + 1'b1)) == '0)
    // Result bits stay inside that packed run.
    `PBE_ASSERT_IMPL(a_result_in_run, o_result.valid,
        (w_data[STEPS].bits & ~w_data[STEPS].mask) == '0)
    // The input register keeps its transaction while the first stage is stalled.
    `PBE_ASSERT_NEXT(a_in_hold, r_in_valid && !w_ready[0], r_in_valid)

endmodule
